// ===== design/matrix_factorization_sgd_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the matrix factorization SGD engine
// Small wrappers that keep the assertion lines in the RTL short.
// ----------------------------------------------------------------------------
`ifndef MATRIX_FACTORIZATION_SGD_ENGINE_ASSERT_SVH
`define MATRIX_FACTORIZATION_SGD_ENGINE_ASSERT_SVH

// An implication checked at every clock edge outside reset.
`define MF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that holds in the cycle after the antecedent.
`define MF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mfsgd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Types and codes shared by the matrix factorization SGD engine.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

   // Table geometry. Both table sizes and the vector length are powers of
   // two, so table addresses are plain concatenations of index and element.
   localparam int DIM   = 16;
   localparam int USERS = 4096;
   localparam int ITEMS = 1024;

   localparam logic [2:0] OP_TRAIN      = 3'd0;
   localparam logic [2:0] OP_ESTIMATE   = 3'd1;
   localparam logic [2:0] OP_WRITE_ITEM = 3'd2;
   localparam logic [2:0] OP_WRITE_USER = 3'd3;
   localparam logic [2:0] OP_READ_ITEM  = 3'd4;
   localparam logic [2:0] OP_READ_USER  = 3'd5;

   localparam logic [1:0] KIND_TRAIN    = 2'd0;
   localparam logic [1:0] KIND_ESTIMATE = 2'd1;
   localparam logic [1:0] KIND_FACTOR   = 2'd2;

   localparam logic [1:0] REG_LEARNING_RATE  = 2'd0;
   localparam logic [1:0] REG_REGULARIZATION = 2'd1;
   localparam logic [1:0] REG_FACTORS_IN_USE = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic [11:0]        user_id;
      logic [9:0]         item_id;
      logic signed [31:0] rating;
      logic [3:0]         factor_index;
      logic signed [31:0] factor_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
      logic signed [31:0] prediction_error;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

endpackage

// ===== design/mfsgd_ram.sv =====
// ----------------------------------------------------------------------------
// mfsgd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfsgd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/matrix_factorization_sgd_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_engine
// SGD trainer over user and item latent factor tables held in block RAM.
// ----------------------------------------------------------------------------
// The engine keeps two RAMs, one word per factor element. Software seeds
// them with write words before reading or training on an entry. A command
// word is taken when start is high and busy is low; busy then stays high
// until the cycle in which the result, if any, is presented on the rsp_
// ports for a single cycle under rsp_valid, and that cycle may already take
// the next word. The receiver cannot stall, so it must capture the result
// word in the cycle it appears. For an estimate or a training word the dot
// product walks the two RAM read ports one element a cycle over the active
// factor count, and a training word then makes an update pass over those
// elements on the single shared 32x32 multiplier and the read-modify-write
// of both tables.
// Software must write the configuration registers only while idle; the
// engine itself does not enforce this.
// ----------------------------------------------------------------------------
`include "matrix_factorization_sgd_engine_assert.svh"

module matrix_factorization_sgd_engine #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  mfsgd_pkg::req_type  req_word,
   output logic                rsp_valid,
   output mfsgd_pkg::rsp_type  rsp_word,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import mfsgd_pkg::*;

   localparam int KW = $clog2(DIM) > 0 ? $clog2(DIM) : 1;
   localparam int UW = $clog2(USERS) > 0 ? $clog2(USERS) : 1;
   localparam int IW = $clog2(ITEMS) > 0 ? $clog2(ITEMS) : 1;
   localparam int UAW = $clog2(USERS * DIM) > 0 ? $clog2(USERS * DIM) : 1;
   localparam int IAW = $clog2(ITEMS * DIM) > 0 ? $clog2(ITEMS * DIM) : 1;
   localparam int CW = $clog2(DIM + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DOT  = 4'd1;
   localparam logic [3:0] S_DSUM = 4'd2;
   localparam logic [3:0] S_ERR  = 4'd3;
   localparam logic [3:0] S_URD  = 4'd4;
   localparam logic [3:0] S_U1   = 4'd5;
   localparam logic [3:0] S_U2   = 4'd6;
   localparam logic [3:0] S_U3   = 4'd7;
   localparam logic [3:0] S_U4   = 4'd8;
   localparam logic [3:0] S_U5   = 4'd9;
   localparam logic [3:0] S_RD   = 4'd10;
   localparam logic [3:0] S_RD2  = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;
   localparam logic [3:0] S_U6   = 4'd13;
   localparam logic [3:0] S_WB   = 4'd14;

   // Configuration registers.
   logic [15:0] lr_ff, lam_ff;
   logic [4:0]  fiu_ff;
   logic        cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= 16'd328;
         lam_ff <= 16'd1311;
         fiu_ff <= 5'd16;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_LEARNING_RATE:  lr_ff  <= pwdata[15:0];
            REG_REGULARIZATION: lam_ff <= pwdata[15:0];
            REG_FACTORS_IN_USE: fiu_ff <= pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_LEARNING_RATE:  prdata = {16'd0, lr_ff};
         REG_REGULARIZATION: prdata = {16'd0, lam_ff};
         REG_FACTORS_IN_USE: prdata = {27'd0, fiu_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // Active element count clamped to 1..DIM.
   logic [CW-1:0] n_act;
   always_comb begin
      if (fiu_ff == 5'd0) n_act = CW'(1);
      else if (32'(fiu_ff) > DIM) n_act = CW'(DIM);
      else n_act = CW'(fiu_ff);
   end

   // Control and item registers.
   logic [3:0]        state_ff, state_in;
   req_type           req_ff;
   logic [UW-1:0]     user_ff;
   logic [IW-1:0]     item_ff;
   logic [CW-1:0]     n_ff;
   logic [CW-1:0]     k_ff, k_in;
   logic              rv_ff, rv_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] est_ff, est_in, err_ff, err_in;
   logic signed [31:0] iv_ff, uv_ff, inew_ff;
   logic signed [63:0] p_ff;         // registered multiplier output
   logic signed [63:0] t_ff;         // first shifted product of a gradient
   logic              pend_ff;       // dot product word waiting in RAM data
   rsp_type           rsp_ff, rsp_in;

   // Memories.
   logic            iw_en, uw_en;
   logic [IAW-1:0]  iw_addr, ir_addr;
   logic [UAW-1:0]  uw_addr, ur_addr;
   logic [31:0]     iw_data, uw_data, ir_data, ur_data;
   logic [KW-1:0]   rd_k;

   mfsgd_ram #(.WIDTH(32), .DEPTH(ITEMS * DIM)) u_item_ram (
      .clock(clock), .wr_en(iw_en), .wr_addr(iw_addr), .wr_data(iw_data),
      .rd_addr(ir_addr), .rd_data(ir_data));
   mfsgd_ram #(.WIDTH(32), .DEPTH(USERS * DIM)) u_user_ram (
      .clock(clock), .wr_en(uw_en), .wr_addr(uw_addr), .wr_data(uw_data),
      .rd_addr(ur_addr), .rd_data(ur_data));

   // Shared multiplier: one 32x32 product per cycle, result registered.
   logic signed [31:0] ma, mb;
   logic signed [63:0] prod;
   assign prod = ma * mb;

   // Arithmetic shift rounds toward minus infinity, as the product demands.
   logic signed [63:0] p_sh;
   assign p_sh = p_ff >>> FRAC_BITS;

   logic in_take;
   assign busy    = (state_ff != S_IDLE);
   assign in_take = start & ~busy;

   // Index reduction modulo table size; both sizes are powers of two, so
   // this keeps the low bits of each index.
   logic [UW-1:0] user_mod;
   logic [IW-1:0] item_mod;
   always_comb begin
      logic [31:0] u, i;
      u = 32'(req_word.user_id);
      i = 32'(req_word.item_id);
      u = u % USERS;
      i = i % ITEMS;
      user_mod = UW'(u);
      item_mod = IW'(i);
   end

   logic fidx_ok;
   assign fidx_ok = (32'(req_ff.factor_index) < DIM);

   assign rd_k = (state_ff == S_IDLE) ? KW'(0) : KW'(k_ff);
   always_comb begin
      ir_addr = IAW'({item_ff, rd_k});
      ur_addr = UAW'({user_ff, rd_k});
      if (state_ff == S_RD) begin
         ir_addr = IAW'({item_ff, req_ff.factor_index[KW-1:0]});
         ur_addr = UAW'({user_ff, req_ff.factor_index[KW-1:0]});
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      rv_in    = 1'b0;
      acc_in   = acc_ff;
      est_in   = est_ff;
      err_in   = err_ff;
      rsp_in   = rsp_ff;
      iw_en    = 1'b0;
      uw_en    = 1'b0;
      iw_addr  = IAW'({item_ff, KW'(k_ff)});
      uw_addr  = UAW'({user_ff, KW'(k_ff)});
      iw_data  = inew_ff;
      uw_data  = 32'(sat32(64'(uv_ff) + p_sh));
      ma       = 32'sd0;
      mb       = 32'sd0;
      case (state_ff)
         S_IDLE: ;
         S_RD: begin
            // Write or read address is presented this cycle.
            if (req_ff.operation == OP_WRITE_ITEM) begin
               iw_en   = fidx_ok;
               iw_addr = IAW'({item_ff, req_ff.factor_index[KW-1:0]});
               iw_data = req_ff.factor_value;
               state_in = S_IDLE;
            end else if (req_ff.operation == OP_WRITE_USER) begin
               uw_en   = fidx_ok;
               uw_addr = UAW'({user_ff, req_ff.factor_index[KW-1:0]});
               uw_data = req_ff.factor_value;
               state_in = S_IDLE;
            end else if (req_ff.operation inside {OP_READ_ITEM, OP_READ_USER}) begin
               state_in = S_RD2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RD2: begin
            rsp_in.kind = KIND_FACTOR;
            rsp_in.prediction_error = 32'sd0;
            if (!fidx_ok) rsp_in.value = 32'sd0;
            else if (req_ff.operation == OP_READ_ITEM) rsp_in.value = ir_data;
            else rsp_in.value = ur_data;
            state_in = S_OUT;
         end
         S_DOT: begin
            // Multiply the element read last cycle, accumulate the one before.
            if (pend_ff) begin
               ma = ur_data;
               mb = ir_data;
            end
            if (k_ff != 0 && k_ff <= n_ff) acc_in = acc_ff + p_sh;
            if (k_ff == n_ff) state_in = S_DSUM;
            k_in = k_ff + CW'(1);
         end
         S_DSUM: begin
            acc_in = acc_ff + p_sh;
            state_in = S_ERR;
         end
         S_ERR: begin
            est_in = sat32(acc_ff);
            err_in = sat32(64'(req_ff.rating) - 64'(sat32(acc_ff)));
            if (req_ff.operation == OP_ESTIMATE) begin
               rsp_in.kind = KIND_ESTIMATE;
               rsp_in.value = sat32(acc_ff);
               rsp_in.prediction_error = 32'sd0;
               state_in = S_OUT;
            end else begin
               k_in = CW'(0);
               state_in = S_URD;
            end
         end
         S_URD: begin
            // Read address for element k is on the RAM ports.
            state_in = S_U1;
         end
         S_U1: begin
            ma = err_ff;             // e * u
            mb = ur_data;
            state_in = S_U2;
         end
         S_U2: begin
            ma = $signed({16'd0, lam_ff});  // lambda * i
            mb = iv_ff;
            state_in = S_U3;
         end
         S_U3: begin
            ma = $signed({16'd0, lr_ff});   // lr * g
            mb = 32'(sat32(t_ff - p_sh));
            state_in = S_U4;
         end
         S_U4: begin
            ma = err_ff;             // e * i'
            mb = 32'(sat32(64'(iv_ff) + p_sh));
            state_in = S_U5;
         end
         S_U5: begin
            ma = $signed({16'd0, lam_ff});  // lambda * u
            mb = uv_ff;
            state_in = S_U6;
         end
         S_U6: begin
            ma = $signed({16'd0, lr_ff});   // lr * g2
            mb = 32'(sat32(t_ff - p_sh));
            state_in = S_WB;
         end
         S_WB: begin
            iw_en = 1'b1;
            uw_en = 1'b1;
            k_in = k_ff + CW'(1);
            if (k_ff + CW'(1) == n_ff) begin
               rsp_in.kind = KIND_TRAIN;
               rsp_in.value = est_ff;
               rsp_in.prediction_error = err_ff;
               state_in = S_OUT;
            end else begin
               state_in = S_URD;
            end
         end
         S_OUT: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (in_take) begin
         k_in = CW'(0);
         acc_in = 64'sd0;
         if (req_word.operation inside {OP_TRAIN, OP_ESTIMATE})
            state_in = S_DOT;
         else
            state_in = S_RD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         pend_ff  <= (state_ff == S_DOT) && (k_ff < n_ff);
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      acc_ff <= acc_in;
      est_ff <= est_in;
      err_ff <= err_in;
      rsp_ff <= rsp_in;
      p_ff   <= prod;
      if (in_take) begin
         req_ff  <= req_word;
         user_ff <= user_mod;
         item_ff <= item_mod;
         n_ff    <= n_act;
      end
      if (state_ff == S_U1) begin
         iv_ff <= ir_data;
         uv_ff <= ur_data;
      end
      if (state_ff == S_U2) t_ff <= p_sh;            // shr(e*u)
      if (state_ff == S_U4) inew_ff <= sat32(64'(iv_ff) + p_sh);
      if (state_ff == S_U5) t_ff <= p_sh;            // shr(e*i')
   end

   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;

   `MF_ASSERT_IMPLY(a_busy_on_rsp, clock, reset, rsp_valid, !busy,
      "result shown while busy")
   `MF_ASSERT_NEXT(a_take_busy, clock, reset, in_take, busy,
      "engine not busy after taking a word")
   `MF_ASSERT_IMPLY(a_no_double_write, clock, reset, iw_en && uw_en,
      state_ff == S_WB, "both tables written outside the update step")
endmodule
